[design/assert_macros.svh]
// Assertion macros for the stack machine execute unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/sme_pkg.sv]
// Package of constants, codes and types for the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VAR_SLOTS   = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VS_W        = (VAR_SLOTS > 2) ? $clog2(VAR_SLOTS) : 1;
    localparam int WORD_W      = 32;
    localparam int MODE_W      = 5;
    localparam int SLOT_W      = 5;
    localparam int DEPTH_W     = 7;
    localparam int STAT_W      = 2;

    // Instruction codes.
    localparam logic [MODE_W-1:0] OP_PUSH    = 5'd0;
    localparam logic [MODE_W-1:0] OP_RVALUE  = 5'd1;
    localparam logic [MODE_W-1:0] OP_LVALUE  = 5'd2;
    localparam logic [MODE_W-1:0] OP_POP     = 5'd3;
    localparam logic [MODE_W-1:0] OP_ASSIGN  = 5'd4;
    localparam logic [MODE_W-1:0] OP_COPY    = 5'd5;
    localparam logic [MODE_W-1:0] OP_ADD     = 5'd6;
    localparam logic [MODE_W-1:0] OP_SUB     = 5'd7;
    localparam logic [MODE_W-1:0] OP_MUL     = 5'd8;
    localparam logic [MODE_W-1:0] OP_DIV     = 5'd9;
    localparam logic [MODE_W-1:0] OP_MOD     = 5'd10;
    localparam logic [MODE_W-1:0] OP_AND     = 5'd11;
    localparam logic [MODE_W-1:0] OP_NOT     = 5'd12;
    localparam logic [MODE_W-1:0] OP_OR      = 5'd13;
    localparam logic [MODE_W-1:0] OP_NE      = 5'd14;
    localparam logic [MODE_W-1:0] OP_LE      = 5'd15;
    localparam logic [MODE_W-1:0] OP_GE      = 5'd16;
    localparam logic [MODE_W-1:0] OP_LT      = 5'd17;
    localparam logic [MODE_W-1:0] OP_GT      = 5'd18;
    localparam logic [MODE_W-1:0] OP_EQ      = 5'd19;
    localparam logic [MODE_W-1:0] OP_PRINT   = 5'd20;
    localparam logic [MODE_W-1:0] OP_GOFALSE = 5'd21;
    localparam logic [MODE_W-1:0] OP_GOTRUE  = 5'd22;

    // Status codes.
    localparam logic [STAT_W-1:0] STS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STS_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] STS_OVER  = 2'd2;
    localparam logic [STAT_W-1:0] STS_DIVZ  = 2'd3;

    // Source of the pushed result.
    typedef logic [1:0] t_src;
    localparam t_src SRC_ALU = 2'd0;
    localparam t_src SRC_MUL = 2'd1;
    localparam t_src SRC_DIV = 2'd2;

    // Kind of execution the current instruction needs.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_SIMPLE = 2'd0;
    localparam t_kind KIND_MUL    = 2'd1;
    localparam t_kind KIND_DIV    = 2'd2;

    typedef struct packed {
        logic load_in;
        logic read;
        logic mul_cap;
        logic div_start;
        logic finish;
        t_src src;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  out_free;
        logic  div_done;
    } t_dp_stat;

    // Number of stack entries an instruction needs on the stack.
    function automatic logic [1:0] op_need(input logic [MODE_W-1:0] mode);
        logic [1:0] n;
        n = 2'd0;
        case (mode) inside
            OP_POP, OP_NOT, OP_PRINT, OP_GOFALSE, OP_GOTRUE, OP_COPY: n = 2'd1;
            OP_ASSIGN, [OP_ADD:OP_AND], [OP_OR:OP_EQ]:                n = 2'd2;
            default:                                                  n = 2'd0;
        endcase
        return n;
    endfunction

    // Whether an instruction needs a free stack entry.
    function automatic logic op_grow(input logic [MODE_W-1:0] mode);
        logic g;
        case (mode) inside
            OP_PUSH, OP_RVALUE, OP_LVALUE, OP_COPY: g = 1'b1;
            default:                                g = 1'b0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

[design/sme_in_if.sv]
// Instruction request channel of the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
interface sme_in_if;
    import sme_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic signed [31:0]   imm_value;
    logic [SLOT_W-1:0]    var_slot;

    modport source(output valid, output mode, output imm_value, output var_slot,
                   input ready);
    modport sink(input valid, input mode, input imm_value, input var_slot,
                 output ready);
endinterface
`default_nettype wire

[design/sme_out_if.sv]
// Result request channel of the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
interface sme_out_if;
    import sme_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   top_value;
    logic [DEPTH_W-1:0]   depth;
    logic signed [31:0]   print_value;
    logic                 printed;
    logic                 branch_taken;
    logic [STAT_W-1:0]    status;

    modport source(output valid, output top_value, output depth, output print_value,
                   output printed, output branch_taken, output status, input ready);
    modport sink(input valid, input top_value, input depth, input print_value,
                 input printed, input branch_taken, input status, output ready);
endinterface
`default_nettype wire

[design/stack_machine_execute.sv]
// Top level of the stack machine execute unit.
// The block takes one stack-machine instruction per request on i_in (mode,
// imm_value, var_slot) and returns one result request on o_out with the new
// top of stack, depth, printed value, branch decision and status.
// Both channels move a request at a clock edge where valid and ready are high.
// An instruction is taken only while the sequencer is idle; it then reads the
// stack memory and variable store in the READ state and executes in the EXEC state.
// Most instructions load the result register from the EXEC state; multiply
// first registers the product and loads it from the MUL state; divide and
// modulo start the divider, which resolves one quotient bit a cycle, and
// load from the DIV state once it is done. The input is ready again when
// the sequencer returns to idle, after the result register is loaded.
// The result sits in an output register, so a new instruction is accepted
// while an earlier result still waits; if the receiver stalls, the next
// result is held in execution until the output register is free.
// At reset the stack is empty and every variable reads as zero; no clearing
// pass is needed, so the block accepts requests right after reset.
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute
    import sme_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sme_in_if.sink    i_in,
    sme_out_if.source o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    sme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    sme_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (i_in.mode),
        .i_imm_value (i_in.imm_value),
        .i_var_slot  (i_in.var_slot),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

[design/sme_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module sme_div
    import sme_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [WORD_W-1:0] o_quotient,
    output logic [WORD_W-1:0] o_remainder
);

    localparam int ITER_W = $clog2(WORD_W + 1);

    logic              r_busy;
    logic [ITER_W-1:0] r_iter;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic              r_neg_q;
    logic              r_neg_r;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_sub;

    // One restoring step on the shifted partial remainder.
    always_comb begin
        rem_sh  = {r_rem, r_quo[WORD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= ITER_W'(WORD_W);
        end else if (r_busy) begin
            r_iter <= r_iter - ITER_W'(1);
            if (r_iter == ITER_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Magnitudes are loaded at start; signs are fixed up at the end.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= i_dividend[WORD_W-1] ? (~i_dividend + WORD_W'(1)) : i_dividend;
            r_dvs   <= i_divisor[WORD_W-1] ? (~i_divisor + WORD_W'(1)) : i_divisor;
            r_neg_q <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
            r_neg_r <= i_dividend[WORD_W-1];
        end else if (r_busy) begin
            if (!rem_sub[WORD_W]) begin
                r_rem <= rem_sub[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_neg_q ? (~r_quo + WORD_W'(1)) : r_quo;
    assign o_remainder = r_neg_r ? (~r_rem + WORD_W'(1)) : r_rem;

endmodule
`default_nettype wire

[design/sme_ctrl.sv]
// Controller state machine of the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sme_ctrl
    import sme_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.src = SRC_ALU;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_stat.kind == KIND_MUL) begin
                    o_cmd.mul_cap = 1'b1;
                    n_state       = ST_MUL;
                end else if (i_stat.kind == KIND_DIV) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_cmd.src = SRC_MUL;
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_DIV: begin
                o_cmd.src = SRC_DIV;
                if (i_stat.div_done && i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SME_ASSERT(a_finish_room, i_clk, i_rst_n, o_cmd.finish |-> i_stat.out_free, "finish without room")
    `SME_ASSERT(a_accept_read, i_clk, i_rst_n, accept |=> (r_state == ST_READ), "accept not followed by read")
    `SME_ASSERT(a_div_wait, i_clk, i_rst_n, o_cmd.div_start |=> !i_stat.div_done, "divider not busy after start")

endmodule
`default_nettype wire

[design/sme_dp.sv]
// Datapath of the stack machine execute unit: stack, variable store, ALU, output register.
`timescale 1ns / 1ps
`default_nettype none
module sme_dp
    import sme_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [WORD_W-1:0]  i_imm_value,
    input  logic [SLOT_W-1:0]  i_var_slot,
    sme_out_if.source          o_out
);

    // Stored instruction.
    logic [MODE_W-1:0]  r_mode;
    logic [WORD_W-1:0]  r_imm;
    logic [SLOT_W-1:0]  r_slot;

    // Stack state: cached top, count, memory and read registers.
    logic [WORD_W-1:0]  stack_mem [STACK_DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [WORD_W-1:0]  r_tos;
    logic [WORD_W-1:0]  r_blw_rd;
    logic [WORD_W-1:0]  r_third_rd;

    // Variable store with valid bits standing in for the zero reset.
    logic [WORD_W-1:0]  var_mem [VAR_SLOTS];
    logic [VAR_SLOTS-1:0] r_var_valid;
    logic [WORD_W-1:0]  r_var_rd;
    logic               r_var_ok;

    logic [WORD_W-1:0]  r_prod;

    // Output register.
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_o_top;
    logic [DEPTH_W-1:0] r_o_depth;
    logic [WORD_W-1:0]  r_o_pval;
    logic               r_o_printed;
    logic               r_o_taken;
    logic [STAT_W-1:0]  r_o_status;

    logic               div_busy;
    logic [WORD_W-1:0]  div_q;
    logic [WORD_W-1:0]  div_r;

    logic [7:0]         slot_ext;
    logic [VS_W-1:0]    rd_vidx;
    logic [VS_W-1:0]    wr_vidx;
    logic               slot_in_range;
    logic [SP_W-1:0]    idx_blw;
    logic [SP_W-1:0]    idx_third;
    logic [SP_W-1:0]    idx_wr;

    logic [WORD_W-1:0]  t;
    logic [WORD_W-1:0]  b;
    logic [1:0]         need;
    logic               grow;
    logic               is_dm;
    logic               ok;
    logic [STAT_W-1:0]  status;
    logic [1:0]         pop_n;
    logic               push;
    logic [WORD_W-1:0]  alu_val;
    logic [WORD_W-1:0]  push_val;
    logic               printed;
    logic               taken;
    logic [CNT_W-1:0]   new_count;
    logic [WORD_W-1:0]  new_top;
    logic               var_wr;

    sme_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (b),
        .i_divisor   (t),
        .o_busy      (div_busy),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // Addresses.
    assign slot_ext      = 8'(r_slot);
    assign rd_vidx       = slot_ext[VS_W-1:0];
    assign wr_vidx       = b[VS_W-1:0];
    assign slot_in_range = (WORD_W'(r_slot) < WORD_W'(VAR_SLOTS));
    assign idx_blw       = SP_W'(r_count - CNT_W'(2));
    assign idx_third     = SP_W'(r_count - CNT_W'(3));
    assign idx_wr        = SP_W'(r_count - CNT_W'(pop_n));

    assign t     = r_tos;
    assign b     = r_blw_rd;
    assign need  = op_need(r_mode);
    assign grow  = op_grow(r_mode);
    assign is_dm = (r_mode == OP_DIV) || (r_mode == OP_MOD);

    // Status checks and the effect of the instruction on the stack.
    always_comb begin
        ok      = 1'b0;
        status  = STS_OK;
        pop_n   = 2'd0;
        push    = 1'b0;
        alu_val = '0;
        printed = 1'b0;
        taken   = 1'b0;
        if (r_mode > OP_GOTRUE) begin
            ok = 1'b0;
        end else if (r_count < CNT_W'(need)) begin
            status = STS_UNDER;
        end else if (grow && (r_count >= CNT_W'(STACK_DEPTH))) begin
            status = STS_OVER;
        end else if (is_dm && (t == '0)) begin
            status = STS_DIVZ;
        end else begin
            ok = 1'b1;
        end
        case (r_mode)
            OP_PUSH:    begin push = 1'b1; alu_val = r_imm; end
            OP_RVALUE:  begin
                push    = 1'b1;
                alu_val = (r_var_ok && slot_in_range) ? r_var_rd : '0;
            end
            OP_LVALUE:  begin push = 1'b1; alu_val = WORD_W'(r_slot); end
            OP_POP:     pop_n = 2'd1;
            OP_ASSIGN:  pop_n = 2'd2;
            OP_COPY:    begin push = 1'b1; alu_val = t; end
            OP_NOT:     begin
                pop_n   = 2'd1;
                push    = (t == WORD_W'(1)) || (t == '0);
                alu_val = WORD_W'(t == '0);
            end
            OP_PRINT:   printed = 1'b1;
            OP_GOFALSE: begin pop_n = 2'd1; taken = (t == '0); end
            OP_GOTRUE:  begin pop_n = 2'd1; taken = (t != '0); end
            default: begin
                pop_n = 2'd2;
                push  = 1'b1;
                case (r_mode)
                    OP_ADD:  alu_val = b + t;
                    OP_SUB:  alu_val = b - t;
                    OP_AND:  alu_val = WORD_W'((t == WORD_W'(1)) && (b == WORD_W'(1)));
                    OP_OR:   alu_val = WORD_W'(!((t == '0) && (b == '0)));
                    OP_NE:   alu_val = WORD_W'($signed(b) != $signed(t));
                    OP_LE:   alu_val = WORD_W'($signed(b) <= $signed(t));
                    OP_GE:   alu_val = WORD_W'($signed(b) >= $signed(t));
                    OP_LT:   alu_val = WORD_W'($signed(b) <  $signed(t));
                    OP_GT:   alu_val = WORD_W'($signed(b) >  $signed(t));
                    OP_EQ:   alu_val = WORD_W'($signed(b) == $signed(t));
                    default: alu_val = '0;
                endcase
            end
        endcase
        if (!ok) begin
            pop_n   = 2'd0;
            push    = 1'b0;
            printed = 1'b0;
            taken   = 1'b0;
        end
    end

    // Pushed value and the new top of stack.
    always_comb begin
        case (i_cmd.src)
            SRC_MUL: push_val = r_prod;
            SRC_DIV: push_val = (r_mode == OP_DIV) ? div_q : div_r;
            default: push_val = alu_val;
        endcase
        new_count = r_count - CNT_W'(pop_n) + CNT_W'(push);
        if (push) begin
            new_top = push_val;
        end else if (new_count == '0) begin
            new_top = '0;
        end else if (pop_n == 2'd0) begin
            new_top = t;
        end else if (pop_n == 2'd1) begin
            new_top = b;
        end else begin
            new_top = r_third_rd;
        end
    end

    assign var_wr = i_cmd.finish && ok && (r_mode == OP_ASSIGN)
                    && (b < WORD_W'(VAR_SLOTS));

    always_comb begin
        o_stat.kind = KIND_SIMPLE;
        if (ok && (r_mode == OP_MUL)) begin
            o_stat.kind = KIND_MUL;
        end else if (ok && is_dm) begin
            o_stat.kind = KIND_DIV;
        end
        o_stat.out_free = !r_out_valid || o_out.ready;
        o_stat.div_done = !div_busy;
    end

    // Instruction capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_mode;
            r_imm  <= i_imm_value;
            r_slot <= i_var_slot;
        end
    end

    // Stack memory: two registered reads and one write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_blw_rd   <= stack_mem[idx_blw];
            r_third_rd <= stack_mem[idx_third];
        end
        if (i_cmd.finish && push) begin
            stack_mem[idx_wr] <= push_val;
        end
    end

    // Variable memory: registered read, one write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_var_rd <= var_mem[rd_vidx];
        end
        if (var_wr) begin
            var_mem[wr_vidx] <= t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_valid <= '0;
            r_var_ok    <= 1'b0;
        end else begin
            if (i_cmd.read) begin
                r_var_ok <= r_var_valid[rd_vidx];
            end
            if (var_wr) begin
                r_var_valid[wr_vidx] <= 1'b1;
            end
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_cap) begin
            r_prod <= b * t;
        end
    end

    // Count and cached top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tos   <= '0;
        end else if (i_cmd.finish) begin
            r_count <= new_count;
            r_tos   <= new_top;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_top     <= new_top;
            r_o_depth   <= DEPTH_W'(new_count);
            r_o_pval    <= printed ? t : '0;
            r_o_printed <= printed;
            r_o_taken   <= taken;
            r_o_status  <= status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.top_value    = r_o_top;
    assign o_out.depth        = r_o_depth;
    assign o_out.print_value  = r_o_pval;
    assign o_out.printed      = r_o_printed;
    assign o_out.branch_taken = r_o_taken;
    assign o_out.status       = r_o_status;

endmodule
`default_nettype wire

[test/stack_machine_execute_tb.sv]
// Testbench for the stack machine execute unit: random and directed instructions checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute_tb;
    import sme_pkg::*;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [31:0]       imm;
        logic [SLOT_W-1:0] slot;
    } t_instr;

    typedef struct {
        logic [31:0]        top;
        logic [DEPTH_W-1:0] depth;
        logic [31:0]        pval;
        logic               printed;
        logic               taken;
        logic [STAT_W-1:0]  status;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    sme_in_if  in_ch();
    sme_out_if out_ch();

    stack_machine_execute u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Predictor state.
    logic [31:0] model_stack [STACK_DEPTH];
    int unsigned model_count;
    logic [31:0] model_vars [VAR_SLOTS];

    t_instr   pending_instrs[$];
    t_outcome expected_outcomes[$];
    int       mismatches;
    int       results_seen;
    int       prints_seen;
    int       branches_seen;
    int       errors_seen;
    longint   cycle_count;
    bit       quiet_send;
    bit       quiet_recv;
    int       hold_cycles;
    bit       stimulus_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Append an instruction to the stimulus queue.
    function automatic void add_instr(input t_instr ins);
        pending_instrs.insert(pending_instrs.size(), ins);
    endfunction

    // Work out the outcome of one instruction and advance the predictor.
    function automatic t_outcome execute_instr(input t_instr ins);
        t_outcome o;
        int unsigned need;
        bit grow;
        logic [31:0] t, b, r;
        bit store;
        o = '{default: '0};
        need = 0;
        grow = 0;
        if (ins.mode <= OP_LVALUE) begin
            grow = 1;
        end else if (ins.mode inside {OP_POP, OP_NOT, OP_PRINT, OP_GOFALSE, OP_GOTRUE}) begin
            need = 1;
        end else if (ins.mode == OP_COPY) begin
            need = 1;
            grow = 1;
        end else if (ins.mode <= OP_EQ) begin
            need = 2;
        end
        if (ins.mode > OP_GOTRUE) begin
            // Unused codes do nothing.
        end else if (model_count < need) begin
            o.status = STS_UNDER;
        end else if (grow && model_count >= STACK_DEPTH) begin
            o.status = STS_OVER;
        end else if (need == 2) begin
            t = model_stack[model_count-1];
            b = model_stack[model_count-2];
            r = '0;
            store = 1;
            if ((ins.mode == OP_DIV || ins.mode == OP_MOD) && t == 0) begin
                o.status = STS_DIVZ;
            end else begin
                case (ins.mode)
                    OP_ASSIGN: begin
                        if (b < VAR_SLOTS) model_vars[b] = t;
                        store = 0;
                    end
                    OP_ADD: r = b + t;
                    OP_SUB: r = b - t;
                    OP_MUL: r = b * t;
                    OP_DIV: begin
                        if (b == 32'h8000_0000 && t == 32'hffff_ffff) r = b;
                        else r = $signed(b) / $signed(t);
                    end
                    OP_MOD: begin
                        if (b == 32'h8000_0000 && t == 32'hffff_ffff) r = '0;
                        else r = $signed(b) % $signed(t);
                    end
                    OP_AND: r = (t == 1 && b == 1);
                    OP_OR:  r = !(t == 0 && b == 0);
                    OP_NE:  r = ($signed(b) != $signed(t));
                    OP_LE:  r = ($signed(b) <= $signed(t));
                    OP_GE:  r = ($signed(b) >= $signed(t));
                    OP_LT:  r = ($signed(b) < $signed(t));
                    OP_GT:  r = ($signed(b) > $signed(t));
                    default: r = (b == t);
                endcase
                model_count -= 2;
                if (store) begin
                    model_stack[model_count] = r;
                    model_count++;
                end
            end
        end else begin
            t = model_count ? model_stack[model_count-1] : '0;
            case (ins.mode)
                OP_PUSH:   begin model_stack[model_count] = ins.imm; model_count++; end
                OP_RVALUE: begin
                    model_stack[model_count] = model_vars[ins.slot];
                    model_count++;
                end
                OP_LVALUE: begin
                    model_stack[model_count] = 32'(ins.slot);
                    model_count++;
                end
                OP_POP:    model_count--;
                OP_COPY:   begin model_stack[model_count] = t; model_count++; end
                OP_NOT: begin
                    model_count--;
                    if (t == 1) begin
                        model_stack[model_count] = 0; model_count++;
                    end else if (t == 0) begin
                        model_stack[model_count] = 1; model_count++;
                    end
                end
                OP_PRINT:   begin o.pval = t; o.printed = 1; end
                OP_GOFALSE: begin model_count--; o.taken = (t == 0); end
                default:    begin model_count--; o.taken = (t != 0); end
            endcase
        end
        o.top = model_count ? model_stack[model_count-1] : '0;
        o.depth = DEPTH_W'(model_count);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at result %0d: %s got %h expected %h", results_seen, what, got,
                 want);
        mismatches++;
    endtask

    function automatic t_instr mk(input logic [MODE_W-1:0] m, input logic [31:0] v = 0,
                                  input logic [SLOT_W-1:0] s = 0);
        t_instr i;
        i.mode = m;
        i.imm = v;
        i.slot = s;
        return i;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'($urandom_range(0, 3));
            4: return 32'($urandom_range(0, 40));
            default: return $urandom;
        endcase
    endfunction

    // Instruction driver: one request per handshake, random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_instrs.size() > 0 && (quiet_send || $urandom_range(0, 99) >= 14)) begin
                t_instr ins;
                ins = pending_instrs.pop_front();
                expected_outcomes.insert(expected_outcomes.size(), execute_instr(ins));
                in_ch.valid <= 1'b1;
                in_ch.mode <= ins.mode;
                in_ch.imm_value <= ins.imm;
                in_ch.var_slot <= ins.slot;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver hold-off counter.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", out_ch.top_value, 0);
                end else begin
                    t_outcome e;
                    e = expected_outcomes.pop_front();
                    if (out_ch.top_value !== e.top) report_mismatch("top", out_ch.top_value, e.top);
                    if (out_ch.depth !== e.depth)
                        report_mismatch("depth", 32'(out_ch.depth), 32'(e.depth));
                    if (out_ch.print_value !== e.pval)
                        report_mismatch("print_value", out_ch.print_value, e.pval);
                    if (out_ch.printed !== e.printed)
                        report_mismatch("printed", 32'(out_ch.printed), 32'(e.printed));
                    if (out_ch.branch_taken !== e.taken)
                        report_mismatch("branch_taken", 32'(out_ch.branch_taken),
                                        32'(e.taken));
                    if (out_ch.status !== e.status)
                        report_mismatch("status", 32'(out_ch.status), 32'(e.status));
                    if (e.printed) prints_seen++;
                    if (e.taken) branches_seen++;
                    if (e.status != STS_OK) errors_seen++;
                end
                results_seen++;
            end
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= quiet_recv || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("timeout with %0d results outstanding", expected_outcomes.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int n;
        int depth_guess;
        int m;
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.imm_value = '0;
        in_ch.var_slot = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        cycle_count = 0;
        mismatches = 0;
        results_seen = 0;
        prints_seen = 0;
        branches_seen = 0;
        errors_seen = 0;
        quiet_send = 0;
        quiet_recv = 0;
        hold_cycles = 0;
        model_count = 0;
        foreach (model_stack[k]) model_stack[k] = '0;
        foreach (model_vars[k]) model_vars[k] = '0;

        // Directed part: underflow on an empty stack, extremes, division corners.
        add_instr(mk(OP_POP));
        add_instr(mk(OP_ADD));
        add_instr(mk(OP_RVALUE, 0, 31));
        add_instr(mk(OP_PUSH, 32'h8000_0000));
        add_instr(mk(OP_PUSH, 32'hffff_ffff));
        add_instr(mk(OP_DIV));
        add_instr(mk(OP_PUSH, 32'h8000_0000));
        add_instr(mk(OP_PUSH, 32'hffff_ffff));
        add_instr(mk(OP_MOD));
        add_instr(mk(OP_PUSH, 0));
        add_instr(mk(OP_DIV));
        add_instr(mk(OP_MOD));
        add_instr(mk(OP_LVALUE, 0, 31));
        add_instr(mk(OP_PUSH, 32'h7fff_ffff));
        add_instr(mk(OP_ASSIGN));
        add_instr(mk(OP_RVALUE, 0, 31));
        add_instr(mk(OP_PUSH, 1));
        add_instr(mk(OP_NOT));
        add_instr(mk(OP_NOT));
        add_instr(mk(OP_PUSH, 5));
        add_instr(mk(OP_NOT));
        add_instr(mk(OP_PRINT));
        add_instr(mk(OP_GOFALSE));
        add_instr(mk(OP_GOTRUE));
        add_instr(mk(5'd31));

        // Random part: depth steered so the stack rises to full and drains to empty.
        depth_guess = 0;
        for (n = 0; n < 1750; n++) begin
            if ((n / 300) % 2 == 0 && $urandom_range(0, 3) != 0) begin
                m = $urandom_range(0, 2);
                if ($urandom_range(0, 5) == 0) m = OP_COPY;
            end else if ($urandom_range(0, 19) == 0) begin
                m = $urandom_range(23, 31);
            end else if ($urandom_range(0, 9) == 0) begin
                // Store through a random address, always within the variable store.
                add_instr(mk(OP_LVALUE, 0, SLOT_W'($urandom)));
                add_instr(mk(OP_PUSH, rand_word()));
                m = OP_ASSIGN;
                n += 2;
            end else begin
                m = $urandom_range(0, 22);
            end
            add_instr(mk(MODE_W'(m), ($urandom_range(0, 1) ? rand_word() : 32'($urandom)),
                         SLOT_W'($urandom)));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Long receiver hold-off while the sender keeps offering requests.
        repeat (200) @(posedge i_clk);
        quiet_send <= 1'b1;
        hold_cycles <= 150;
        repeat (600) @(posedge i_clk);
        quiet_send <= 1'b0;
        repeat (2000) @(posedge i_clk);
        quiet_send <= 1'b1;
        quiet_recv <= 1'b1;
        repeat (1500) @(posedge i_clk);
        quiet_send <= 1'b0;
        quiet_recv <= 1'b0;

        wait (pending_instrs.size() == 0 && expected_outcomes.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("Checked %0d instructions over every mode and the stack extremes.",
                 results_seen);
        $display("Prints %0d, branches taken %0d, error statuses %0d.", prints_seen,
                 branches_seen, errors_seen);
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[stack_machine_execute.f]
+incdir+design
design/sme_pkg.sv
design/sme_in_if.sv
design/sme_out_if.sv
design/sme_div.sv
design/sme_ctrl.sv
design/sme_dp.sv
design/stack_machine_execute.sv
test/stack_machine_execute_tb.sv
